### rtl/nhqpe_pkg.sv
package nhqpe_pkg;

	localparam int SUB_DEPTH  = 128;
	localparam int COMP_DEPTH = 256;

	localparam int SPTR_W = $clog2(SUB_DEPTH);
	localparam int CPTR_W = $clog2(COMP_DEPTH);
	localparam int SQ_W   = 8;
	localparam int CQ_W   = 9;
	localparam int TAG_W  = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_SUB_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COMP_SIZE = 2'd1;

	localparam logic CMD_SUBMIT   = 1'b0;
	localparam logic CMD_COMPLETE = 1'b1;

	typedef enum logic [2:0] {
		OUT_SUBMITTED = 3'd0,
		OUT_FULL      = 3'd1,
		OUT_DONE_OK   = 3'd2,
		OUT_DONE_ERR  = 3'd3,
		OUT_STALE     = 3'd4,
		OUT_BAD_ID    = 3'd5
	} outcome_t;

	typedef struct packed {
		logic        command;
		logic [15:0] request_tag;
		logic        entry_phase;
		logic [15:0] entry_id;
		logic [7:0]  entry_status;
		logic [6:0]  entry_sub_head;
	} req_t;

	typedef struct packed {
		logic [2:0]  outcome;
		logic [6:0]  given_id;
		logic [6:0]  slot_index;
		logic [6:0]  sub_tail_doorbell;
		logic [7:0]  comp_head_doorbell;
		logic [15:0] returned_tag;
		logic [7:0]  returned_status;
	} rsp_t;

	// clamped queue sizes
	typedef struct packed {
		logic [SQ_W-1:0] sq;
		logic [CQ_W-1:0] cq;
	} cfg_t;

endpackage

### rtl/nhqpe_cfg.sv
module nhqpe_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [nhqpe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nhqpe_pkg::CFG_DATA_W-1:0]   cfg_data,
	output nhqpe_pkg::cfg_t                    cfg
);
	import nhqpe_pkg::*;

	logic [SQ_W-1:0] sq_q;
	logic [CQ_W-1:0] cq_q;
	logic [SQ_W-1:0] sq_raw;
	logic [CQ_W-1:0] cq_raw;
	logic [SQ_W-1:0] sq_clamp;
	logic [CQ_W-1:0] cq_clamp;

	assign cfg_ready = 1'b1;

	always_comb begin
		sq_raw = cfg_data[SQ_W-1:0];
		cq_raw = cfg_data[CQ_W-1:0];
		if (sq_raw < SQ_W'(2))
			sq_clamp = SQ_W'(2);
		else if (sq_raw > SQ_W'(SUB_DEPTH))
			sq_clamp = SQ_W'(SUB_DEPTH);
		else
			sq_clamp = sq_raw;
		if (cq_raw < CQ_W'(2))
			cq_clamp = CQ_W'(2);
		else if (cq_raw > CQ_W'(COMP_DEPTH))
			cq_clamp = CQ_W'(COMP_DEPTH);
		else
			cq_clamp = cq_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q <= SQ_W'(SUB_DEPTH);
			cq_q <= CQ_W'(COMP_DEPTH);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SUB_SIZE:  sq_q <= sq_clamp;
				CFG_COMP_SIZE: cq_q <= cq_clamp;
				default: ;
			endcase
		end
	end

	assign cfg.sq = sq_q;
	assign cfg.cq = cq_q;

endmodule

### rtl/nhqpe_tag_mem.sv
module nhqpe_tag_mem (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [nhqpe_pkg::SPTR_W-1:0]     wr_addr,
	input  logic [nhqpe_pkg::TAG_W-1:0]      wr_data,
	input  logic [nhqpe_pkg::SPTR_W-1:0]     rd_addr,
	output logic [nhqpe_pkg::TAG_W-1:0]      rd_data
);
	import nhqpe_pkg::*;

	logic [TAG_W-1:0] mem [SUB_DEPTH];
	logic [TAG_W-1:0] rd_q;
	logic [TAG_W-1:0] fwd_q;
	logic             fwd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q  <= mem[rd_addr];
		fwd_q <= wr_data;
	end

	// write-first: a read colliding with this cycle's write sees the new tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fwd_hit_q <= 1'b0;
		else
			fwd_hit_q <= wr_en && (wr_addr == rd_addr);
	end

	assign rd_data = fwd_hit_q ? fwd_q : rd_q;

endmodule

### rtl/nhqpe_core.sv
module nhqpe_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  nhqpe_pkg::req_t               request,
	input  nhqpe_pkg::cfg_t               cfg,
	output logic                          tag_wr_en,
	output logic [nhqpe_pkg::SPTR_W-1:0]  tag_wr_addr,
	output logic [nhqpe_pkg::TAG_W-1:0]   tag_wr_data,
	input  logic [nhqpe_pkg::TAG_W-1:0]   tag_rd_data,
	output logic                          result_valid,
	output nhqpe_pkg::rsp_t               result
);
	import nhqpe_pkg::*;

	logic                valid_s1;
	req_t                req_s1;

	logic [SPTR_W-1:0]   sub_tail_q;
	logic [SPTR_W-1:0]   sub_head_q;
	logic [CPTR_W-1:0]   comp_head_q;
	logic                phase_q;
	logic [SUB_DEPTH-1:0] id_busy_q;

	logic                result_valid_q;
	rsp_t                result_q;

	logic                free_found;
	logic [SPTR_W-1:0]   free_id;
	logic [SPTR_W:0]     tail_inc;
	logic [SPTR_W-1:0]   tail_next;
	logic [CPTR_W:0]     head_inc;
	logic [CPTR_W-1:0]   head_next;
	logic [SPTR_W-1:0]   cid;
	logic                cid_ok;

	logic                do_alloc;
	logic                do_free;
	logic                do_consume;
	rsp_t                rsp_d;

	always_comb begin
		free_found = 1'b0;
		free_id    = '0;
		for (int i = SUB_DEPTH - 1; i >= 0; i--) begin
			if (!id_busy_q[i] && (i < int'(cfg.sq))) begin
				free_found = 1'b1;
				free_id    = SPTR_W'(i);
			end
		end
	end

	always_comb begin
		tail_inc  = {1'b0, sub_tail_q} + (SPTR_W+1)'(1);
		tail_next = ((SQ_W+1)'(tail_inc) >= (SQ_W+1)'(cfg.sq)) ? '0 : tail_inc[SPTR_W-1:0];
		head_inc  = {1'b0, comp_head_q} + (CPTR_W+1)'(1);
		head_next = ((CQ_W+1)'(head_inc) >= (CQ_W+1)'(cfg.cq)) ? '0 : head_inc[CPTR_W-1:0];
		cid       = req_s1.entry_id[SPTR_W-1:0];
		cid_ok    = (req_s1.entry_id[15:SPTR_W] == '0)
			&& ((SQ_W+1)'(cid) < (SQ_W+1)'(cfg.sq)) && id_busy_q[cid];
	end

	always_comb begin
		do_alloc   = 1'b0;
		do_free    = 1'b0;
		do_consume = 1'b0;
		rsp_d                    = '0;
		rsp_d.sub_tail_doorbell  = 7'(sub_tail_q);
		rsp_d.comp_head_doorbell = 8'(comp_head_q);
		if (req_s1.command == CMD_SUBMIT) begin
			if (!free_found || (tail_next == sub_head_q)) begin
				rsp_d.outcome = OUT_FULL;
			end else begin
				do_alloc                = valid_s1;
				rsp_d.outcome           = OUT_SUBMITTED;
				rsp_d.given_id          = 7'(free_id);
				rsp_d.slot_index        = 7'(sub_tail_q);
				rsp_d.sub_tail_doorbell = 7'(tail_next);
			end
		end else begin
			rsp_d.given_id = req_s1.entry_id[6:0];
			if (req_s1.entry_phase != phase_q) begin
				rsp_d.outcome = OUT_STALE;
			end else begin
				do_consume               = valid_s1;
				rsp_d.comp_head_doorbell = 8'(head_next);
				if (cid_ok) begin
					do_free               = valid_s1;
					rsp_d.outcome         = (req_s1.entry_status == '0) ? OUT_DONE_OK : OUT_DONE_ERR;
					rsp_d.returned_tag    = tag_rd_data;
					rsp_d.returned_status = req_s1.entry_status;
				end else begin
					rsp_d.outcome = OUT_BAD_ID;
				end
			end
		end
	end

	assign tag_wr_en   = do_alloc;
	assign tag_wr_addr = free_id;
	assign tag_wr_data = req_s1.request_tag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			sub_tail_q     <= '0;
			sub_head_q     <= '0;
			comp_head_q    <= '0;
			phase_q        <= 1'b1;
			id_busy_q      <= '0;
		end else begin
			valid_s1       <= accept;
			result_valid_q <= valid_s1;
			if (do_alloc) begin
				id_busy_q[free_id] <= 1'b1;
				sub_tail_q         <= tail_next;
			end
			if (do_free) begin
				id_busy_q[cid] <= 1'b0;
				sub_head_q     <= req_s1.entry_sub_head;
			end
			if (do_consume) begin
				comp_head_q <= head_next;
				if (head_next == '0)
					phase_q <= ~phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= request;
		if (valid_s1)
			result_q <= rsp_d;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### rtl/nvme_host_queue_pair_engine_top.sv
// channel   handshake               payload
// request   start / busy            request (req_t)
// result    result_valid strobe     result (rsp_t)
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request per cycle; busy stays low. The result strobe and the result are
// registered together: input register, then ID search, pointer wrap and tag
// lookup into the result register. The tag memory read is registered at accept.
// Reset clears pointers and the ID busy bits, sets the phase to one and the
// sizes to their maximum. The result side cannot stall.
module nvme_host_queue_pair_engine_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  nhqpe_pkg::req_t                    request,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [nhqpe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nhqpe_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                               result_valid,
	output nhqpe_pkg::rsp_t                    result
);
	import nhqpe_pkg::*;

	cfg_t              cfg;
	logic              accept;
	logic              tag_wr_en;
	logic [SPTR_W-1:0] tag_wr_addr;
	logic [TAG_W-1:0]  tag_wr_data;
	logic [TAG_W-1:0]  tag_rd_data;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	nhqpe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	nhqpe_tag_mem u_tag_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tag_wr_en),
		.wr_addr (tag_wr_addr),
		.wr_data (tag_wr_data),
		.rd_addr (request.entry_id[SPTR_W-1:0]),
		.rd_data (tag_rd_data)
	);

	nhqpe_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.request      (request),
		.cfg          (cfg),
		.tag_wr_en    (tag_wr_en),
		.tag_wr_addr  (tag_wr_addr),
		.tag_wr_data  (tag_wr_data),
		.tag_rd_data  (tag_rd_data),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
